// ===== rtl/core/flpd_pkg.sv =====
// Shared types and constants for the fast link pulse burst page decoder.
// No dependencies; imported by every module of the block.
package flpd_pkg;

    localparam int WORD_BITS = 16;
    localparam int CNT_W     = $clog2(WORD_BITS);
    localparam int CFG_W     = 24;
    localparam int IDX_W     = 3;

    // Queue between the pulse classifier and the page machine.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH_MIN = 3'd1;
    localparam logic [IDX_W-1:0] REG_WIDTH_MAX = 3'd2;
    localparam logic [IDX_W-1:0] REG_ONE_MIN   = 3'd3;
    localparam logic [IDX_W-1:0] REG_ONE_MAX   = 3'd4;
    localparam logic [IDX_W-1:0] REG_ZERO_MIN  = 3'd5;
    localparam logic [IDX_W-1:0] REG_ZERO_MAX  = 3'd6;

    // Output codes.
    localparam logic [1:0] STATE_BASE     = 2'd0;
    localparam logic [1:0] STATE_BASE_ACK = 2'd1;
    localparam logic [1:0] STATE_NEXT     = 2'd2;
    localparam logic [1:0] STATE_NEXT_ACK = 2'd3;

    localparam logic [1:0] SEL_UNKNOWN = 2'd0;
    localparam logic [1:0] SEL_8023    = 2'd1;
    localparam logic [1:0] SEL_8029    = 2'd2;

    typedef enum logic [3:0] {
        PH_BASE     = 4'b0001,
        PH_BASE_ACK = 4'b0010,
        PH_NEXT     = 4'b0100,
        PH_NEXT_ACK = 4'b1000
    } flpd_phase_t;

    typedef struct packed {
        logic             enable;
        logic [CFG_W-1:0] width_min;
        logic [CFG_W-1:0] width_max;
        logic [CFG_W-1:0] one_gap_min;
        logic [CFG_W-1:0] one_gap_max;
        logic [CFG_W-1:0] zero_gap_min;
        logic [CFG_W-1:0] zero_gap_max;
    } flpd_cfg_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } flpd_qstat_t;

    function automatic logic [1:0] phase_code(input flpd_phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_BASE:     code = STATE_BASE;
            PH_BASE_ACK: code = STATE_BASE_ACK;
            PH_NEXT:     code = STATE_NEXT;
            PH_NEXT_ACK: code = STATE_NEXT_ACK;
            default:     code = STATE_BASE;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/flpd_front.sv =====
// Pulse classifier: width check, gap to reference, bit assembly into page words.
// Depends on flpd_pkg; pushes finished words into flpd_queue.
module flpd_front #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  flpd_pkg::flpd_cfg_t     cfg,
    input  logic                    accept,
    input  logic [TIME_WIDTH-1:0]   rise_time,
    input  logic [TIME_WIDTH-1:0]   end_time,
    output logic                    push,
    output logic [flpd_pkg::WORD_BITS-1:0] push_word,
    output logic [TIME_WIDTH-1:0]   push_start,
    output logic [TIME_WIDTH-1:0]   push_end
);
    import flpd_pkg::*;

    localparam int PAD_W = TIME_WIDTH - CFG_W;

    logic [TIME_WIDTH-1:0] reference_reg, reference_next;
    logic [TIME_WIDTH-1:0] prev_rise_reg, prev_rise_next;
    logic [TIME_WIDTH-1:0] first_start_reg, first_start_next;
    logic [WORD_BITS-1:0]  shift_reg, shift_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic [TIME_WIDTH-1:0] width, gap;
    logic                  is_link, is_one, is_zero, act, got_bit, last_bit;
    logic [WORD_BITS-1:0]  bit_mask;

    always_comb begin
        width    = end_time - rise_time;
        gap      = rise_time - reference_reg;
        is_link  = (width >= {{PAD_W{1'b0}}, cfg.width_min})
                && (width <= {{PAD_W{1'b0}}, cfg.width_max});
        is_one   = (gap >= {{PAD_W{1'b0}}, cfg.one_gap_min})
                && (gap <= {{PAD_W{1'b0}}, cfg.one_gap_max});
        is_zero  = (gap >= {{PAD_W{1'b0}}, cfg.zero_gap_min})
                && (gap <= {{PAD_W{1'b0}}, cfg.zero_gap_max});
        act      = accept && cfg.enable && is_link;
        got_bit  = act && (is_one || is_zero);
        last_bit = (count_reg == CNT_W'(WORD_BITS - 1));
        bit_mask = is_one ? (WORD_BITS'(1) << count_reg) : '0;

        reference_next   = reference_reg;
        prev_rise_next   = prev_rise_reg;
        first_start_next = first_start_reg;
        shift_next       = shift_reg;
        count_next       = count_reg;

        if (act) begin
            // A one clears the reference: the following clock pulse only re-arms it.
            reference_next = is_one ? '0 : rise_time;
            prev_rise_next = rise_time;
        end
        if (got_bit) begin
            if (count_reg == '0) begin
                first_start_next = prev_rise_reg;
            end
            if (last_bit) begin
                shift_next = '0;
                count_next = '0;
            end else begin
                shift_next = shift_reg | bit_mask;
                count_next = count_reg + CNT_W'(1);
            end
        end

        push       = got_bit && last_bit;
        push_word  = shift_reg | bit_mask;
        push_start = first_start_reg;
        push_end   = is_one ? end_time : (end_time - (gap >> 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reference_reg   <= '0;
            prev_rise_reg   <= '0;
            first_start_reg <= '0;
            shift_reg       <= '0;
            count_reg       <= '0;
        end else begin
            reference_reg   <= reference_next;
            prev_rise_reg   <= prev_rise_next;
            first_start_reg <= first_start_next;
            shift_reg       <= shift_next;
            count_reg       <= count_next;
        end
    end

endmodule

// ===== rtl/core/flpd_queue.sv =====
// Short word queue between the classifier and the page machine.
// Depends on flpd_pkg for depth and status type.
module flpd_queue #(
    parameter int DATA_W = 112
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [DATA_W-1:0]     push_data,
    input  logic                  pop,
    output logic [DATA_W-1:0]     head_data,
    output flpd_pkg::flpd_qstat_t status
);
    import flpd_pkg::*;

    logic [DATA_W-1:0]  data_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    always_comb begin
        status.full     = (count_reg == Q_CNT_W'(Q_DEPTH));
        status.nonempty = (count_reg != '0);
        do_push = push && !status.full;
        do_pop  = pop && status.nonempty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_PTR_W'(1);
        end
        count_next = count_reg + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        head_data  = data_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/flpd_back.sv =====
// Page machine: base/next page acknowledge tracking, field split, output register.
// Depends on flpd_pkg; pops words from flpd_queue.
module flpd_back #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  logic [flpd_pkg::WORD_BITS-1:0] q_word,
    input  logic [TIME_WIDTH-1:0]          q_start,
    input  logic [TIME_WIDTH-1:0]          q_end,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [15:0]                    m_page_word,
    output logic [1:0]                     m_page_state,
    output logic                           m_is_next_page,
    output logic [1:0]                     m_selector_kind,
    output logic [10:0]                    m_ability_bits,
    output logic                           m_message_page,
    output logic [4:0]                     m_other_bits,
    output logic [TIME_WIDTH-1:0]          m_word_start,
    output logic [TIME_WIDTH-1:0]          m_word_end
);
    import flpd_pkg::*;

    flpd_phase_t          phase_reg, phase_next;
    logic [WORD_BITS-1:0] last_word_reg;
    logic                 valid_reg;

    logic [15:0]           word_reg;
    logic [1:0]            state_reg;
    logic                  np_reg;
    logic [1:0]            sel_reg, sel_next;
    logic [10:0]           ability_reg, ability_next;
    logic                  msg_reg, msg_next;
    logic [4:0]            other_reg, other_next;
    logic [TIME_WIDTH-1:0] start_reg, end_reg;
    logic                  np_next;
    logic [1:0]            top_bits;

    always_comb begin
        pop      = q_valid && (!valid_reg || m_ready);
        top_bits = q_word[15:14];

        // Advance only when the page differs from the previous one.
        phase_next = phase_reg;
        if (q_word != last_word_reg) begin
            case (phase_reg)
                PH_BASE:     phase_next = (top_bits == 2'b11) ? PH_BASE_ACK : PH_BASE;
                PH_BASE_ACK: phase_next = PH_NEXT;
                PH_NEXT:     phase_next = (top_bits == 2'b01) ? PH_NEXT_ACK : PH_NEXT;
                PH_NEXT_ACK: phase_next = PH_BASE;
                default:     phase_next = PH_BASE;
            endcase
        end
        np_next = (phase_next == PH_NEXT) || (phase_next == PH_NEXT_ACK);

        if (np_next) begin
            sel_next     = SEL_UNKNOWN;
            ability_next = q_word[10:0];
            msg_next     = q_word[13];
            other_next   = q_word[15:11];
        end else begin
            if (q_word[4:0] == 5'd1) begin
                sel_next = SEL_8023;
            end else if (q_word[4:0] == 5'd2) begin
                sel_next = SEL_8029;
            end else begin
                sel_next = SEL_UNKNOWN;
            end
            ability_next = {3'b000, q_word[12:5]};
            msg_next     = 1'b0;
            other_next   = {2'b00, q_word[15:13]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_BASE;
            last_word_reg <= '0;
            valid_reg     <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg     <= phase_next;
                last_word_reg <= q_word;
                valid_reg     <= 1'b1;
            end else if (m_ready) begin
                valid_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            word_reg    <= q_word;
            state_reg   <= phase_code(phase_next);
            np_reg      <= np_next;
            sel_reg     <= sel_next;
            ability_reg <= ability_next;
            msg_reg     <= msg_next;
            other_reg   <= other_next;
            start_reg   <= q_start;
            end_reg     <= q_end;
        end
    end

    assign m_valid         = valid_reg;
    assign m_page_word     = word_reg;
    assign m_page_state    = state_reg;
    assign m_is_next_page  = np_reg;
    assign m_selector_kind = sel_reg;
    assign m_ability_bits  = ability_reg;
    assign m_message_page  = msg_reg;
    assign m_other_bits    = other_reg;
    assign m_word_start    = start_reg;
    assign m_word_end      = end_reg;

endmodule

// ===== rtl/core/flp_burst_page_decoder_top.sv =====
// Top level of the fast link pulse burst page decoder: config registers and wiring.
// Depends on flpd_pkg, flpd_front, flpd_queue and flpd_back.
//
// Usage:
//   Input channel (s_valid/s_ready): one word per line pulse, carrying the rise
//   and end sample numbers. Pulses whose width falls in the width window are
//   link pulses; their spacing to the reference pulse decodes a one or a zero.
//   Output channel (m_valid/m_ready): one word per sixteen decoded bits, with
//   the assembled page, the base/next page acknowledge state and its fields.
//   Config channel (cfg_valid/cfg_ready): always ready; write registers only
//   while the block is idle. Index 7 is ignored.
// Throughput: one input word per cycle while s_ready is high. The classifier closes its
//   gap-to-reference loop (one wide subtract and window compare) every cycle.
// Path: a page enters the queue as the pulse carrying its sixteenth bit is
//   accepted, then moves to the output register once that register is free.
// Reset: clears all decode state, the page machine goes to base page and the
//   registers take their defaults with decoding off.
// Stall: a stalled receiver holds the output word; finished pages wait in a
//   two-entry queue and s_ready drops only while that queue is full.
module flp_burst_page_decoder_top #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [23:0]           cfg_data,
    // pulse input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [TIME_WIDTH-1:0] s_rise_time,
    input  logic [TIME_WIDTH-1:0] s_end_time,
    // page output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [15:0]           m_page_word,
    output logic [1:0]            m_page_state,
    output logic                  m_is_next_page,
    output logic [1:0]            m_selector_kind,
    output logic [10:0]           m_ability_bits,
    output logic                  m_message_page,
    output logic [4:0]            m_other_bits,
    output logic [TIME_WIDTH-1:0] m_word_start,
    output logic [TIME_WIDTH-1:0] m_word_end
);
    import flpd_pkg::*;

    localparam int Q_DATA_W = WORD_BITS + 2 * TIME_WIDTH;

    flpd_cfg_t   cfg_reg;
    flpd_qstat_t q_status;

    logic                  s_accept;
    logic                  fe_push;
    logic [WORD_BITS-1:0]  fe_word;
    logic [TIME_WIDTH-1:0] fe_start, fe_end;
    logic [Q_DATA_W-1:0]   q_head;
    logic                  be_pop;

    // Registers take a write whenever offered; unknown indexes drop.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.width_min    <= CFG_W'(100);
            cfg_reg.width_max    <= CFG_W'(1000);
            cfg_reg.one_gap_min  <= CFG_W'(6000);
            cfg_reg.one_gap_max  <= CFG_W'(7000);
            cfg_reg.zero_gap_min <= CFG_W'(12000);
            cfg_reg.zero_gap_max <= CFG_W'(14000);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ENABLE:    cfg_reg.enable       <= cfg_data[0];
                REG_WIDTH_MIN: cfg_reg.width_min    <= cfg_data;
                REG_WIDTH_MAX: cfg_reg.width_max    <= cfg_data;
                REG_ONE_MIN:   cfg_reg.one_gap_min  <= cfg_data;
                REG_ONE_MAX:   cfg_reg.one_gap_max  <= cfg_data;
                REG_ZERO_MIN:  cfg_reg.zero_gap_min <= cfg_data;
                REG_ZERO_MAX:  cfg_reg.zero_gap_max <= cfg_data;
                default:       cfg_reg.enable       <= cfg_reg.enable;
            endcase
        end
    end

    // Hold off input only when a finished page could find no room.
    assign s_ready  = !q_status.full;
    assign s_accept = s_valid && s_ready;

    flpd_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .accept     (s_accept),
        .rise_time  (s_rise_time),
        .end_time   (s_end_time),
        .push       (fe_push),
        .push_word  (fe_word),
        .push_start (fe_start),
        .push_end   (fe_end)
    );

    flpd_queue #(
        .DATA_W (Q_DATA_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fe_push),
        .push_data ({fe_word, fe_start, fe_end}),
        .pop       (be_pop),
        .head_data (q_head),
        .status    (q_status)
    );

    flpd_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_status.nonempty),
        .q_word          (q_head[Q_DATA_W-1 -: WORD_BITS]),
        .q_start         (q_head[2*TIME_WIDTH-1 -: TIME_WIDTH]),
        .q_end           (q_head[TIME_WIDTH-1:0]),
        .pop             (be_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_page_word     (m_page_word),
        .m_page_state    (m_page_state),
        .m_is_next_page  (m_is_next_page),
        .m_selector_kind (m_selector_kind),
        .m_ability_bits  (m_ability_bits),
        .m_message_page  (m_message_page),
        .m_other_bits    (m_other_bits),
        .m_word_start    (m_word_start),
        .m_word_end      (m_word_end)
    );

    // Next page flag must agree with the reported page state.
    a_np_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_next_page == m_page_state[1]))
        else $error("next page flag disagrees with page state");

    // Base pages carry no message bit and only three other bits.
    a_base_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_next_page) |-> (!m_message_page && m_other_bits[4:3] == 2'b00))
        else $error("base page field split wrong");

    // Next pages report no selector.
    a_np_selector: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_next_page) |-> (m_selector_kind == SEL_UNKNOWN))
        else $error("selector on a next page");

    // With decoding off no page is ever produced.
    a_disabled_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_reg.enable |-> !fe_push)
        else $error("page pushed while decoding off");

endmodule

// ===== test/flpd_page_checker.sv =====
// Scoreboard for the fast link pulse page decoder: follows register writes, predicts
// each page word from accepted pulse words and compares every page word that leaves.
// Depends on flpd_pkg for register indexes, output codes and the config struct.
`timescale 1ns / 100ps

module flpd_page_checker
    import flpd_pkg::*;
#(
    parameter int TW = 48
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data,
    input  logic          s_valid,
    input  logic          s_ready,
    input  logic [TW-1:0] s_rise_time,
    input  logic [TW-1:0] s_end_time,
    input  logic          m_valid,
    input  logic          m_ready,
    input  logic [15:0]   m_page_word,
    input  logic [1:0]    m_page_state,
    input  logic          m_is_next_page,
    input  logic [1:0]    m_selector_kind,
    input  logic [10:0]   m_ability_bits,
    input  logic          m_message_page,
    input  logic [4:0]    m_other_bits,
    input  logic [TW-1:0] m_word_start,
    input  logic [TW-1:0] m_word_end,
    output int            fail_count,
    output int            open_pages,
    output int            pages_predicted
);

    typedef struct packed {
        logic [15:0]   word;
        logic [1:0]    state;
        logic          next_page;
        logic [1:0]    selector;
        logic [10:0]   ability;
        logic          message;
        logic [4:0]    other;
        logic [TW-1:0] start_t;
        logic [TW-1:0] end_t;
    } page_t;

    flpd_cfg_t     regs;
    logic [TW-1:0] anchor_t;    // reference pulse; zero right after a one
    logic [TW-1:0] last_rise;
    logic [TW-1:0] lead_rise;
    logic [15:0]   bits_in;
    logic [4:0]    bit_cnt;
    logic [1:0]    phase;
    logic [15:0]   prev_word;
    page_t         expected_pages[$];
    int            errors = 0;
    int            predicted = 0;

    function automatic bit in_range(input logic [TW-1:0] v, input logic [CFG_W-1:0] lo,
                                    input logic [CFG_W-1:0] hi);
        return (v >= TW'(lo)) && (v <= TW'(hi));
    endfunction

    // Advance the decode state by one pulse; return 1 when a page completes.
    function automatic bit decode_pulse(input logic [TW-1:0] rise, input logic [TW-1:0] fin,
                                        output page_t pg);
        logic [TW-1:0] width, gap, fin_adj;
        logic [15:0]   w;
        pg      = '0;
        fin_adj = '0;
        if (!regs.enable) return 1'b0;
        width = fin - rise;
        if (in_range(width, regs.width_min, regs.width_max)) begin
            gap      = rise - anchor_t;
            anchor_t = rise;
            if (in_range(gap, regs.one_gap_min, regs.one_gap_max)) begin
                if (bit_cnt == 5'd0) lead_rise = last_rise;
                bits_in[bit_cnt[3:0]] = 1'b1;
                fin_adj  = fin;
                bit_cnt  = bit_cnt + 5'd1;
                anchor_t = '0;
            end else if (in_range(gap, regs.zero_gap_min, regs.zero_gap_max)) begin
                if (bit_cnt == 5'd0) lead_rise = last_rise;
                fin_adj = fin - (gap >> 1);
                bit_cnt = bit_cnt + 5'd1;
            end
            last_rise = rise;
        end
        if (bit_cnt < 5'(WORD_BITS)) return 1'b0;

        w = bits_in;
        if (w != prev_word) begin
            case (phase)
                STATE_BASE:     if (w[15:14] == 2'b11) phase = STATE_BASE_ACK;
                STATE_BASE_ACK: phase = STATE_NEXT;
                STATE_NEXT:     if (w[15:14] == 2'b01) phase = STATE_NEXT_ACK;
                default:        phase = STATE_BASE;
            endcase
        end
        pg.word      = w;
        pg.state     = phase;
        pg.next_page = (phase == STATE_NEXT) || (phase == STATE_NEXT_ACK);
        if (pg.next_page) begin
            pg.selector = SEL_UNKNOWN;
            pg.ability  = w[10:0];
            pg.message  = w[13];
            pg.other    = w[15:11];
        end else begin
            pg.selector = (w[4:0] == 5'd1) ? SEL_8023 :
                          (w[4:0] == 5'd2) ? SEL_8029 : SEL_UNKNOWN;
            pg.ability  = {3'b000, w[12:5]};
            pg.message  = 1'b0;
            pg.other    = {2'b00, w[15:13]};
        end
        pg.start_t = lead_rise;
        pg.end_t   = fin_adj;
        prev_word  = w;
        bit_cnt    = '0;
        bits_in    = '0;
        return 1'b1;
    endfunction

    task automatic report(input string msg);
        errors++;
        $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string what, input logic [TW-1:0] got,
                               input logic [TW-1:0] want);
        if (got !== want)
            report($sformatf("page field %s: got %0h, want %0h", what, got, want));
    endtask

    always @(posedge aclk) begin
        page_t fresh, want;
        if (!aresetn) begin
            regs.enable       = 1'b0;
            regs.width_min    = 24'd100;
            regs.width_max    = 24'd1000;
            regs.one_gap_min  = 24'd6000;
            regs.one_gap_max  = 24'd7000;
            regs.zero_gap_min = 24'd12000;
            regs.zero_gap_max = 24'd14000;
            anchor_t  = '0;
            last_rise = '0;
            lead_rise = '0;
            bits_in   = '0;
            bit_cnt   = '0;
            phase     = STATE_BASE;
            prev_word = '0;
            expected_pages.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ENABLE:    regs.enable       = cfg_data[0];
                    REG_WIDTH_MIN: regs.width_min    = cfg_data;
                    REG_WIDTH_MAX: regs.width_max    = cfg_data;
                    REG_ONE_MIN:   regs.one_gap_min  = cfg_data;
                    REG_ONE_MAX:   regs.one_gap_max  = cfg_data;
                    REG_ZERO_MIN:  regs.zero_gap_min = cfg_data;
                    REG_ZERO_MAX:  regs.zero_gap_max = cfg_data;
                    default: ;
                endcase
            end
            // compare before predicting: a page cannot leave on the edge its last pulse enters
            if (m_valid && m_ready) begin
                if (expected_pages.size() == 0) begin
                    report($sformatf("unexpected page word %h", m_page_word));
                end else begin
                    want = expected_pages.pop_front();
                    check_field("page_word", TW'(m_page_word), TW'(want.word));
                    check_field("page_state", TW'(m_page_state), TW'(want.state));
                    check_field("is_next_page", TW'(m_is_next_page), TW'(want.next_page));
                    check_field("selector_kind", TW'(m_selector_kind), TW'(want.selector));
                    check_field("ability_bits", TW'(m_ability_bits), TW'(want.ability));
                    check_field("message_page", TW'(m_message_page), TW'(want.message));
                    check_field("other_bits", TW'(m_other_bits), TW'(want.other));
                    check_field("word_start", m_word_start, want.start_t);
                    check_field("word_end", m_word_end, want.end_t);
                end
            end
            if (s_valid && s_ready) begin
                if (decode_pulse(s_rise_time, s_end_time, fresh)) begin
                    expected_pages.push_back(fresh);
                    predicted++;
                end
            end
        end
        fail_count      <= errors;
        open_pages      <= expected_pages.size();
        pages_predicted <= predicted;
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the fast link pulse burst page decoder: clock, reset, register
// setup, pulse stimulus, receiver back-pressure and the final verdict.
// Depends on flpd_pkg, flp_burst_page_decoder_top and flpd_page_checker.
`timescale 1ns / 100ps

module tb;
    import flpd_pkg::*;

    localparam int TW          = 48;
    localparam int ITEMS       = 1250;
    localparam int RAND_PHASES = 7;
    localparam int PHASE_ITEMS = ITEMS / RAND_PHASES;
    localparam int LONG_HOLD   = 800;
    localparam int SETTLE      = 12;
    // The limit allows for the slowest sane run: long sender gaps, receiver stalls
    // and one long hold-off.
    localparam int LIMIT       = 400_000;
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [23:0]   cfg_data = '0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [TW-1:0] s_rise_time = '0;
    logic [TW-1:0] s_end_time = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [15:0]   m_page_word;
    logic [1:0]    m_page_state;
    logic          m_is_next_page;
    logic [1:0]    m_selector_kind;
    logic [10:0]   m_ability_bits;
    logic          m_message_page;
    logic [4:0]    m_other_bits;
    logic [TW-1:0] m_word_start;
    logic [TW-1:0] m_word_end;

    int fail_count;
    int open_pages;
    int pages_predicted;

    logic [CFG_W-1:0] plan [0:7];      // register values, by index, for the next setup
    logic [TW-1:0]    beat;            // time of the pulse the next bit is spaced from
    logic [15:0]      last_page = '0;
    int               items_sent = 0;
    int               quiet_left = 0;
    bit               quiet = 1'b0;
    int               cycles = 0;
    logic             stall_req = 1'b0;
    bit               stall_taken = 1'b0;

    flp_burst_page_decoder_top #(.TIME_WIDTH(TW)) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rise_time     (s_rise_time),
        .s_end_time      (s_end_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_page_word     (m_page_word),
        .m_page_state    (m_page_state),
        .m_is_next_page  (m_is_next_page),
        .m_selector_kind (m_selector_kind),
        .m_ability_bits  (m_ability_bits),
        .m_message_page  (m_message_page),
        .m_other_bits    (m_other_bits),
        .m_word_start    (m_word_start),
        .m_word_end      (m_word_end)
    );

    flpd_page_checker #(.TW(TW)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rise_time     (s_rise_time),
        .s_end_time      (s_end_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_page_word     (m_page_word),
        .m_page_state    (m_page_state),
        .m_is_next_page  (m_is_next_page),
        .m_selector_kind (m_selector_kind),
        .m_ability_bits  (m_ability_bits),
        .m_message_page  (m_message_page),
        .m_other_bits    (m_other_bits),
        .m_word_start    (m_word_start),
        .m_word_end      (m_word_end),
        .fail_count      (fail_count),
        .open_pages      (open_pages),
        .pages_predicted (pages_predicted)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("flp_burst_page_decoder_top verification failed");
            $finish;
        end
    end

    // Receiver: alternate ready and stall runs, mostly short stalls, a few long ones.
    // Once the stimulus asks for it, hold off for a long stretch so the page queue
    // fills and the block has to drop s_ready.
    initial begin
        int n, r;
        @(posedge aclk);
        forever begin
            if (stall_req && !stall_taken) begin
                stall_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
                repeat (n) @(posedge aclk);
                r = $urandom_range(0, 99);
                n = (r < 70) ? $urandom_range(1, 3) :
                    (r < 95) ? $urandom_range(4, 10) : $urandom_range(20, 60);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Sender gap after each word: runs of back-to-back words alternate with runs of
    // random gaps, most short and a few long.
    task automatic pause();
        int n, r;
        if (quiet_left == 0) begin
            quiet      = ($urandom_range(0, 3) == 0);
            quiet_left = $urandom_range(10, 60);
        end
        quiet_left--;
        n = 0;
        if (!quiet) begin
            r = $urandom_range(0, 99);
            if (r >= 97)      n = $urandom_range(20, 60);
            else if (r >= 85) n = $urandom_range(4, 12);
            else if (r >= 55) n = $urandom_range(1, 3);
        end
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Offer one pulse word and hold it until accepted. Valid stays high into the
    // next word when no gap follows.
    task automatic send_item(input logic [TW-1:0] rise, input logic [TW-1:0] fin);
        s_valid     <= 1'b1;
        s_rise_time <= rise;
        s_end_time  <= fin;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        pause();
    endtask

    task automatic link_pulse(input logic [TW-1:0] rise);
        send_item(rise, rise + TW'($urandom_range(plan[REG_WIDTH_MIN], plan[REG_WIDTH_MAX])));
    endtask

    // A one is a data pulse in the one window, followed by a clock pulse that
    // only re-arms the reference. A zero is the next clock pulse in the zero window.
    task automatic send_bit(input logic b);
        logic [TW-1:0] r;
        if (b) begin
            r = beat + TW'($urandom_range(plan[REG_ONE_MIN], plan[REG_ONE_MAX]));
            link_pulse(r);
            beat = r + TW'($urandom_range(plan[REG_ONE_MIN], plan[REG_ONE_MAX]));
            link_pulse(beat);
        end else begin
            beat = beat + TW'($urandom_range(plan[REG_ZERO_MIN], plan[REG_ZERO_MAX]));
            link_pulse(beat);
        end
    endtask

    // Leading clock pulse after a long silence, then the page bits, bit 0 first.
    // Fewer than sixteen bits makes a broken burst.
    task automatic send_page(input logic [15:0] w, input int nbits);
        beat = beat + TW'(plan[REG_ZERO_MAX]) + TW'($urandom_range(1000, 50000));
        link_pulse(beat);
        for (int i = 0; i < nbits; i++) send_bit(w[i]);
    endtask

    // Bias page words toward acknowledge patterns, known selectors and repeats.
    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 5))
            0: w = last_page;
            1: w[15:14] = 2'b11;
            2: w[15:14] = 2'b01;
            3: w[4:0] = 5'($urandom_range(1, 2));
            default: ;
        endcase
        last_page = w;
        return w;
    endfunction

    task automatic send_noise();
        logic [TW-1:0] r;
        r = beat + TW'($urandom_range(0, 2 * plan[REG_ZERO_MAX]));
        case ($urandom_range(0, 3))
            0: send_item(TW'({$urandom, $urandom}), TW'({$urandom, $urandom}));
            1: send_item(r, r + TW'(plan[REG_WIDTH_MAX]) + TW'(1)
                            + TW'($urandom_range(0, 5000)));            // too wide
            2: send_item(r, r - TW'(1) - TW'($urandom_range(0, 50)));   // ends early
            default: begin                                              // stray pulse
                beat = r;
                link_pulse(beat);
            end
        endcase
    endtask

    // Mostly whole pages with random content, some broken bursts and noise.
    task automatic run_phase(input int budget, input int page_floor);
        int first, r;
        first = items_sent;
        while ((items_sent - first < budget || pages_predicted < page_floor) &&
               items_sent - first < 4 * budget + 2000) begin
            r = $urandom_range(0, 99);
            if (r < 70)      send_page(pick_word(), 16);
            else if (r < 80) send_page(pick_word(), $urandom_range(1, 15));
            else             repeat ($urandom_range(1, 4)) send_noise();
        end
    endtask

    // Drop valid, wait until every page predicted has left, then let the pipe empty.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (open_pages != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write every register back to back, enable last; optionally hit the spare index.
    task automatic configure(input logic en, input logic [CFG_W-1:0] wmin, wmax,
                             omin, omax, zmin, zmax, input bit with_spare);
        logic [IDX_W-1:0] seq [8];
        settle();
        plan[REG_ENABLE]    = CFG_W'(en);
        plan[REG_WIDTH_MIN] = wmin;
        plan[REG_WIDTH_MAX] = wmax;
        plan[REG_ONE_MIN]   = omin;
        plan[REG_ONE_MAX]   = omax;
        plan[REG_ZERO_MIN]  = zmin;
        plan[REG_ZERO_MAX]  = zmax;
        plan[REG_SPARE]     = CFG_W'($urandom);
        seq = '{REG_SPARE, REG_WIDTH_MIN, REG_WIDTH_MAX, REG_ONE_MIN, REG_ONE_MAX,
                REG_ZERO_MIN, REG_ZERO_MAX, REG_ENABLE};
        for (int k = with_spare ? 0 : 1; k < 8; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= seq[k];
            cfg_data  <= plan[seq[k]];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, wrap, the spacing-after-a-one rule, then zeros.
        configure(1'b1, 24'd100, 24'd1000, 24'd6000, 24'd7000, 24'd12000, 24'd14000, 1'b1);
        send_item('0, '1);                      // widest pulse: not a link pulse
        send_item('1, TW'(499));                // width wraps round to 500
        send_item(TW'(6500), TW'(7000));        // spacing across the wrap is a one
        send_item(TW'(13000), TW'(13000));      // zero width: ignored
        send_item(TW'(6800), TW'(7300));        // reference cleared, spacing is the rise
        beat = TW'(100000);
        send_item(beat, beat + TW'(500));
        repeat (14) send_bit(1'b0);             // completes the first page

        // Nominal timing; the receiver holds off long enough to fill the block.
        stall_req <= 1'b1;
        run_phase(PHASE_ITEMS, 0);

        // Sample counter wraps mid-phase.
        configure(1'b1, 24'd50, 24'd2000, 24'd6000, 24'd7000, 24'd12000, 24'd14000, 1'b0);
        beat = '1 - TW'(1_000_000);
        run_phase(PHASE_ITEMS, 0);

        // Overlapping bit windows: the one wins.
        configure(1'b1, 24'd0, 24'd2000, 24'd5000, 24'd9000, 24'd8000, 24'd14000, 1'b0);
        run_phase(PHASE_ITEMS, 0);

        // Widest settings.
        configure(1'b1, 24'd0, 24'hFFFFFF, 24'd0, 24'h3FFFFF, 24'h800000, 24'hFFFFFF, 1'b0);
        beat = TW'({$urandom, $urandom});
        run_phase(PHASE_ITEMS, 0);

        // Empty one window, single allowed width.
        configure(1'b1, 24'd500, 24'd500, 24'd7000, 24'd6000, 24'd12000, 24'd14000, 1'b0);
        run_phase(PHASE_ITEMS, 0);

        // Empty zero window.
        configure(1'b1, 24'd100, 24'd1000, 24'd6000, 24'd7000, 24'd14000, 24'd12000, 1'b0);
        run_phase(PHASE_ITEMS, 0);

        // Decoding off, then an empty width window: every word is dropped.
        configure(1'b0, 24'd100, 24'd1000, 24'd6000, 24'd7000, 24'd12000, 24'd14000, 1'b0);
        run_phase(30, 0);
        configure(1'b1, 24'd1000, 24'd100, 24'd6000, 24'd7000, 24'd12000, 24'd14000, 1'b0);
        run_phase(30, 0);

        // Narrowest settings near time zero.
        configure(1'b1, 24'd0, 24'd0, 24'd1, 24'd3, 24'd4, 24'd8, 1'b0);
        beat = '0;
        run_phase(PHASE_ITEMS, 0);

        settle();
        if (fail_count == 0) begin
            $display("flp_burst_page_decoder_top verification clean");
        end else begin
            $display("flp_burst_page_decoder_top verification failed");
        end
        $finish;
    end

endmodule
